/* src/fixed_block_pool_allocator_assert.svh */
// Assertion macros for the fixed-block pool allocator.
// Used at the end of the top level; expects i_clk and i_rst_n in scope.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define FBPA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked out of reset
`define FBPA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

/* src/fbpa_pkg.sv */
// Shared types and constants for the fixed-block pool allocator.
// No dependencies; used by every module of the block but fbpa_ram.
`timescale 1ns / 1ps

package fbpa_pkg;

    // Pool size default
    localparam int MAX_SLOTS_DEF = 1024;

    // Field widths
    localparam int REQ_W      = 1;
    localparam int FREE_W     = 10;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 10;
    localparam int OFFSET_W   = 22;
    localparam int LIMIT_W    = 11;
    localparam int OBJ_W      = 13;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Result status codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_BAD_FREE = 2'd2;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SLOT_LIMIT = 2'd0;
    localparam t_cfg_idx CFG_OBJ_SIZE   = 2'd1;

    // Configuration reset values
    localparam logic [LIMIT_W-1:0] LIMIT_RST    = 11'd1024;
    localparam logic [OBJ_W-1:0]   OBJ_SIZE_RST = 13'd64;

    // Free stack control and status
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_stack_stat;

endpackage

/* src/fbpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/fbpa_stack.sv */
// LIFO of freed slot indexes: depth counter, top-of-stack register and a RAM
// that prefetches the entry below the top. Depends on fbpa_pkg and fbpa_ram.
`timescale 1ns / 1ps

module fbpa_stack #(
    parameter int MAX_SLOTS = fbpa_pkg::MAX_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fbpa_pkg::t_stack_ctl         i_ctl,
    input  logic [$clog2(MAX_SLOTS)-1:0] i_push_data,
    output logic [$clog2(MAX_SLOTS)-1:0] o_top,
    output fbpa_pkg::t_stack_stat        o_stat
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    logic [CNT_W-1:0] r_depth;
    logic [CNT_W-1:0] n_depth;
    logic [IDX_W-1:0] r_top;
    logic [IDX_W-1:0] n_top;
    logic [CNT_W-1:0] w_below_ptr;
    logic [IDX_W-1:0] w_below;
    logic             w_push;
    logic             w_pop;

    assign o_stat.empty = (r_depth == '0);
    assign o_stat.full  = (r_depth == CNT_W'(MAX_SLOTS));

    assign w_push = i_ctl.push && !o_stat.full;
    assign w_pop  = i_ctl.pop && !o_stat.empty;

    // Next depth and top; a pop promotes the prefetched entry below the top
    always_comb begin
        n_depth = r_depth;
        n_top   = r_top;
        if (w_push) begin
            n_depth = r_depth + CNT_W'(1);
            n_top   = i_push_data;
        end else if (w_pop) begin
            n_depth = r_depth - CNT_W'(1);
            n_top   = w_below;
        end
    end

    // Prefetch address: entry two below the next depth
    assign w_below_ptr = n_depth - CNT_W'(2);

    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_depth[IDX_W-1:0]),
        .i_wdata (i_push_data),
        .i_raddr (w_below_ptr[IDX_W-1:0]),
        .o_rdata (w_below)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    assign o_top = r_top;

endmodule

/* src/fbpa_clear.sv */
// Post-reset sweep that walks every in-use flag address once.
// Depends on fbpa_pkg for the default pool size.
`timescale 1ns / 1ps

module fbpa_clear #(
    parameter int MAX_SLOTS = fbpa_pkg::MAX_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    output logic                         o_busy,
    output logic [$clog2(MAX_SLOTS)-1:0] o_addr
);

    localparam int IDX_W = $clog2(MAX_SLOTS);

    logic             r_busy;
    logic [IDX_W-1:0] r_addr;

    // One address per cycle, stop after the last slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else if (r_busy) begin
            if (r_addr == IDX_W'(MAX_SLOTS - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_addr <= r_addr + IDX_W'(1);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_addr = r_addr;

endmodule

/* src/fixed_block_pool_allocator.sv */
// Fixed-block pool allocator: one request per cycle while results are taken, each
// answered with one result through the input register, then the result register.
// The sustained rate is one request per clock when the result side does not stall,
// set by the single read port of the in-use flag RAM, which is read at acceptance
// and forwarded around the write of the request ahead. After reset a sweep clears
// the in-use flags, during which no request is accepted; configuration writes are
// taken at all times. Allocation reuses the most recently freed slot before
// handing out a never-used one. Depends on fbpa_pkg, fbpa_ram, fbpa_stack,
// fbpa_clear and the assertion macro header.
`timescale 1ns / 1ps

module fixed_block_pool_allocator #(
    parameter int MAX_SLOTS = fbpa_pkg::MAX_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Requests
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [fbpa_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [9:0] free_slot, [15:10] zero
    input  logic [fbpa_pkg::REQ_W-1:0]        s_axis_tuser,  // [0] req_type
    // Results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [fbpa_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // [9:0] slot, [31:10] byte_offset
    output logic [fbpa_pkg::STATUS_W-1:0]     m_axis_tuser,  // [1:0] status
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int LIM_W  = (CNT_W > fbpa_pkg::LIMIT_W) ? CNT_W : fbpa_pkg::LIMIT_W;
    localparam int PROD_W = fbpa_pkg::SLOT_W + fbpa_pkg::OBJ_W;

    // Configuration registers
    logic [fbpa_pkg::LIMIT_W-1:0] r_slot_limit;
    logic [fbpa_pkg::OBJ_W-1:0]   r_obj_size;

    // Input stage
    logic                          r_s1_valid;
    logic                          r_s1_req;
    logic [fbpa_pkg::FREE_W-1:0]   r_s1_fs;

    // Result stage
    logic                          r_out_valid;
    fbpa_pkg::t_status             r_out_status;
    logic [fbpa_pkg::SLOT_W-1:0]   r_out_slot;
    logic [fbpa_pkg::OFFSET_W-1:0] r_out_offset;

    // Bump allocator and forwarding
    logic [CNT_W-1:0]              r_bump;
    logic                          r_fwd_hit;
    logic                          r_fwd_val;

    logic                          w_clr_busy;
    logic [IDX_W-1:0]              w_clr_addr;
    logic                          w_in_acc;
    logic                          w_s1_adv;
    logic [LIM_W-1:0]              w_lim;
    logic [LIM_W-1:0]              w_in_fs_ext;
    logic [LIM_W-1:0]              w_s1_fs_ext;
    logic                          w_use_we;
    logic [IDX_W-1:0]              w_use_waddr;
    logic                          w_use_wdata;
    logic [IDX_W-1:0]              w_use_raddr;
    logic                          w_use_rd;
    logic                          w_in_use;
    fbpa_pkg::t_stack_ctl          w_stk_ctl;
    fbpa_pkg::t_stack_stat         w_stk_stat;
    logic [IDX_W-1:0]              w_stk_top;
    logic                          w_pop;
    logic                          w_bump_ok;
    logic                          w_alloc_ok;
    logic                          w_free_ok;
    logic [IDX_W-1:0]              w_grant_idx;
    logic [LIM_W-1:0]              w_grant_ext;
    fbpa_pkg::t_status             w_status;
    logic [fbpa_pkg::SLOT_W-1:0]   w_slot;
    logic [PROD_W-1:0]             w_prod;

    // Configuration writes, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit <= fbpa_pkg::LIMIT_RST;
            r_obj_size   <= fbpa_pkg::OBJ_SIZE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fbpa_pkg::CFG_SLOT_LIMIT: r_slot_limit <= i_cfg_data[fbpa_pkg::LIMIT_W-1:0];
                fbpa_pkg::CFG_OBJ_SIZE:   r_obj_size   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective limit: min(slot_limit, MAX_SLOTS)
    assign w_lim = (LIM_W'(r_slot_limit) < LIM_W'(MAX_SLOTS)) ?
                   LIM_W'(r_slot_limit) : LIM_W'(MAX_SLOTS);

    // Post-reset flag sweep
    fbpa_clear #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (w_clr_busy),
        .o_addr  (w_clr_addr)
    );

    // Handshake: input stage moves on when the result register can take it
    assign w_s1_adv      = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !w_clr_busy && (!r_s1_valid || w_s1_adv);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_req <= s_axis_tuser[0];
            r_s1_fs  <= s_axis_tdata[fbpa_pkg::FREE_W-1:0];
        end
    end

    assign w_in_fs_ext = LIM_W'(s_axis_tdata[fbpa_pkg::FREE_W-1:0]);
    assign w_s1_fs_ext = LIM_W'(r_s1_fs);

    // Free stack
    fbpa_stack #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_stk_ctl),
        .i_push_data (w_s1_fs_ext[IDX_W-1:0]),
        .o_top       (w_stk_top),
        .o_stat      (w_stk_stat)
    );

    // Decision for the request in the input stage
    assign w_pop       = !w_stk_stat.empty;
    assign w_bump_ok   = LIM_W'(r_bump) < w_lim;
    assign w_alloc_ok  = w_pop || w_bump_ok;
    assign w_grant_idx = w_pop ? w_stk_top : r_bump[IDX_W-1:0];
    assign w_grant_ext = LIM_W'(w_grant_idx);
    assign w_in_use    = r_fwd_hit ? r_fwd_val : w_use_rd;
    assign w_free_ok   = (w_s1_fs_ext < w_lim) && w_in_use;

    assign w_stk_ctl.push = w_s1_adv && (r_s1_req == fbpa_pkg::REQ_FREE) && w_free_ok;
    assign w_stk_ctl.pop  = w_s1_adv && (r_s1_req == fbpa_pkg::REQ_ALLOC) && w_pop;

    always_comb begin
        w_status = fbpa_pkg::ST_OK;
        w_slot   = '0;
        if (r_s1_req == fbpa_pkg::REQ_ALLOC) begin
            if (w_alloc_ok) begin
                w_slot = w_grant_ext[fbpa_pkg::SLOT_W-1:0];
            end else begin
                w_status = fbpa_pkg::ST_FULL;
            end
        end else if (!w_free_ok) begin
            w_status = fbpa_pkg::ST_BAD_FREE;
        end
    end

    assign w_prod = PROD_W'(w_slot) * PROD_W'(r_obj_size);

    // Bump counter advances only when the free stack is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bump <= '0;
        end else if (w_s1_adv && (r_s1_req == fbpa_pkg::REQ_ALLOC) && !w_pop && w_bump_ok) begin
            r_bump <= r_bump + CNT_W'(1);
        end
    end

    // In-use flags: sweep writes during clear, else the committing request
    always_comb begin
        if (w_clr_busy) begin
            w_use_we    = 1'b1;
            w_use_waddr = w_clr_addr;
            w_use_wdata = 1'b0;
        end else if (r_s1_req == fbpa_pkg::REQ_ALLOC) begin
            w_use_we    = w_s1_adv && w_alloc_ok;
            w_use_waddr = w_grant_idx;
            w_use_wdata = 1'b1;
        end else begin
            w_use_we    = w_s1_adv && w_free_ok;
            w_use_waddr = w_s1_fs_ext[IDX_W-1:0];
            w_use_wdata = 1'b0;
        end
    end

    // Read the incoming slot, or hold the address of the stalled one
    assign w_use_raddr = w_in_acc ? w_in_fs_ext[IDX_W-1:0] : w_s1_fs_ext[IDX_W-1:0];

    fbpa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_SLOTS)
    ) u_use_ram (
        .i_clk   (i_clk),
        .i_we    (w_use_we),
        .i_waddr (w_use_waddr),
        .i_wdata (w_use_wdata),
        .i_raddr (w_use_raddr),
        .o_rdata (w_use_rd)
    );

    // Forward a write that lands on the address read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= w_use_we && (w_use_waddr == w_use_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_val <= w_use_wdata;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_status <= w_status;
            r_out_slot   <= w_slot;
            r_out_offset <= w_prod[fbpa_pkg::OFFSET_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_offset, r_out_slot};
    assign m_axis_tuser  = r_out_status;

    // Checks
    `include "fixed_block_pool_allocator_assert.svh"

    `FBPA_ASSERT_IMP(a_no_accept_in_clear, w_clr_busy, !s_axis_tready && !r_s1_valid)
    `FBPA_ASSERT_NXT(a_full_reported, w_s1_adv && (r_s1_req == fbpa_pkg::REQ_ALLOC) && !w_alloc_ok, r_out_valid && (r_out_status == fbpa_pkg::ST_FULL))
    `FBPA_ASSERT_NXT(a_free_fills_stack, w_stk_ctl.push, !w_stk_stat.empty && (r_out_status == fbpa_pkg::ST_OK))

endmodule

/* sim/tb_top.sv */
// Self-checking bench for the fixed-block pool allocator: directed and random
// alloc/free traffic, mostly under random stalls, checked against an in-bench pool model.
// Depends on fbpa_pkg and the fixed_block_pool_allocator RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int POOL_SLOTS  = fbpa_pkg::MAX_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYC  = 4;

    // Register index that decodes to nothing
    localparam fbpa_pkg::t_cfg_idx CFG_SPARE = 2'd3;

    typedef struct packed {
        fbpa_pkg::t_status             status;
        logic [fbpa_pkg::SLOT_W-1:0]   slot;
        logic [fbpa_pkg::OFFSET_W-1:0] offset;
    } t_grant;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // DUT ports
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [fbpa_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;  // [9:0] free_slot, [15:10] zero
    logic [fbpa_pkg::REQ_W-1:0]      s_axis_tuser  = '0;  // [0] req_type
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [fbpa_pkg::M_TDATA_W-1:0]  m_axis_tdata;        // [9:0] slot, [31:10] byte_offset
    logic [fbpa_pkg::STATUS_W-1:0]   m_axis_tuser;        // [1:0] status
    logic                            i_cfg_valid   = 1'b0;
    logic                            o_cfg_ready;
    logic [fbpa_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [fbpa_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;

    fixed_block_pool_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Pool model state
    logic [fbpa_pkg::LIMIT_W-1:0] pool_limit = fbpa_pkg::LIMIT_RST;
    logic [fbpa_pkg::OBJ_W-1:0]   obj_bytes  = fbpa_pkg::OBJ_SIZE_RST;
    int                           bump_next   = 0;
    int                           stack_depth = 0;
    logic [fbpa_pkg::SLOT_W-1:0]  freed_stack [POOL_SLOTS];
    bit                           slot_busy   [POOL_SLOTS];
    int                           live_slots[$];
    t_grant                       grant_q[$];

    int  miss_count = 0;
    int  cycles     = 0;
    bit  idle_on    = 1'b1;

    // Apply one accepted request to the pool model and queue its result
    task automatic predict_grant(input logic kind, input int fs);
        int     eff;
        int     s;
        t_grant g;
        eff = (pool_limit < POOL_SLOTS) ? int'(pool_limit) : POOL_SLOTS;
        g   = '0;
        if (kind == fbpa_pkg::REQ_ALLOC) begin
            s = -1;
            if (stack_depth > 0) begin
                stack_depth--;
                s = freed_stack[stack_depth];
            end else if (bump_next < eff) begin
                s = bump_next;
                bump_next++;
            end else begin
                g.status = fbpa_pkg::ST_FULL;
            end
            if (s >= 0) begin
                slot_busy[s] = 1'b1;
                live_slots.push_back(s);
                g.slot   = s[fbpa_pkg::SLOT_W-1:0];
                g.offset = fbpa_pkg::OFFSET_W'(s * int'(obj_bytes));
            end
        end else if (fs >= eff || !slot_busy[fs]) begin
            g.status = fbpa_pkg::ST_BAD_FREE;
        end else begin
            freed_stack[stack_depth] = fs[fbpa_pkg::SLOT_W-1:0];
            stack_depth++;
            slot_busy[fs] = 1'b0;
            for (int i = 0; i < live_slots.size(); i++) begin
                if (live_slots[i] == fs) begin
                    live_slots.delete(i);
                    break;
                end
            end
        end
        grant_q.push_back(g);
    endtask

    // Send one request; tvalid stays high afterwards so requests can run back to back
    task automatic send_req(input logic kind, input logic [fbpa_pkg::FREE_W-1:0] fs);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(fbpa_pkg::S_TDATA_W-fbpa_pkg::FREE_W){1'b0}}, fs};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_grant(kind, int'(fs));
    endtask

    // Random request: frees mostly target live slots, the rest is noise
    task automatic send_random(input int alloc_pct, input int live_pct);
        logic kind;
        int   fs;
        kind = ($urandom_range(0, 99) < alloc_pct) ? fbpa_pkg::REQ_ALLOC : fbpa_pkg::REQ_FREE;
        fs   = $urandom_range(0, POOL_SLOTS - 1);
        if (kind == fbpa_pkg::REQ_FREE && live_slots.size() > 0
            && $urandom_range(0, 99) < live_pct)
            fs = live_slots[$urandom_range(0, live_slots.size() - 1)];
        send_req(kind, fs[fbpa_pkg::FREE_W-1:0]);
    endtask

    // Stop requests and wait until every pending result has drained
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Register write; only called while the pool is idle
    task automatic write_reg(input fbpa_pkg::t_cfg_idx idx,
                             input logic [fbpa_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == fbpa_pkg::CFG_SLOT_LIMIT)
            pool_limit = val[fbpa_pkg::LIMIT_W-1:0];
        else if (idx == fbpa_pkg::CFG_OBJ_SIZE)
            obj_bytes = val[fbpa_pkg::OBJ_W-1:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic note_miss(input string what, input int want, input int got);
        miss_count++;
        if (miss_count <= MAX_REPORTS)
            $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (grant_q.size() == 0) begin
                note_miss("unexpected result, status", -1, int'(m_axis_tuser));
            end else begin
                want = grant_q.pop_front();
                if (m_axis_tuser !== want.status)
                    note_miss("status", int'(want.status), int'(m_axis_tuser));
                if (m_axis_tdata[fbpa_pkg::SLOT_W-1:0] !== want.slot)
                    note_miss("slot", int'(want.slot),
                              int'(m_axis_tdata[fbpa_pkg::SLOT_W-1:0]));
                if (m_axis_tdata[fbpa_pkg::SLOT_W +: fbpa_pkg::OFFSET_W] !== want.offset)
                    note_miss("byte_offset", int'(want.offset),
                              int'(m_axis_tdata[fbpa_pkg::SLOT_W +: fbpa_pkg::OFFSET_W]));
            end
        end
    end

    // Result-side backpressure in random bursts while idle_on is set
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!idle_on) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Reset values: reuse of a freed slot, double free, free of a never-used slot
    task automatic test_reuse_defaults();
        send_req(fbpa_pkg::REQ_ALLOC, '0);
        send_req(fbpa_pkg::REQ_ALLOC, '1);
        send_req(fbpa_pkg::REQ_FREE, 10'd1);
        send_req(fbpa_pkg::REQ_FREE, 10'd1);
        send_req(fbpa_pkg::REQ_FREE, 10'd1023);
        send_req(fbpa_pkg::REQ_ALLOC, 10'h2AA);
        send_req(fbpa_pkg::REQ_FREE, 10'd0);
        send_req(fbpa_pkg::REQ_FREE, 10'd1);
    endtask

    // Zero limit, lowered limit with slots still stacked, out-of-range limit
    task automatic test_limit_edges();
        wait_idle();
        write_reg(fbpa_pkg::CFG_SLOT_LIMIT, 13'd0);
        send_req(fbpa_pkg::REQ_ALLOC, 10'h155);
        send_req(fbpa_pkg::REQ_ALLOC, '0);
        send_req(fbpa_pkg::REQ_ALLOC, '0);
        send_req(fbpa_pkg::REQ_FREE, 10'd0);
        wait_idle();
        write_reg(fbpa_pkg::CFG_SLOT_LIMIT, 13'd1);
        write_reg(CFG_SPARE, 13'd0);
        send_req(fbpa_pkg::REQ_FREE, 10'd1);
        send_req(fbpa_pkg::REQ_FREE, 10'd0);
        send_req(fbpa_pkg::REQ_ALLOC, '0);
        send_req(fbpa_pkg::REQ_ALLOC, '0);
        wait_idle();
        write_reg(fbpa_pkg::CFG_SLOT_LIMIT, 13'h1FFF);
        send_req(fbpa_pkg::REQ_FREE, 10'd1);
    endtask

    // Object size extremes, zero size included
    task automatic test_offset_extremes();
        wait_idle();
        write_reg(fbpa_pkg::CFG_OBJ_SIZE, 13'd0);
        send_req(fbpa_pkg::REQ_ALLOC, '0);
        wait_idle();
        write_reg(fbpa_pkg::CFG_OBJ_SIZE, 13'd4096);
        send_req(fbpa_pkg::REQ_ALLOC, '0);
        wait_idle();
        write_reg(fbpa_pkg::CFG_OBJ_SIZE, 13'h1FFF);
        send_req(fbpa_pkg::REQ_ALLOC, '0);
    endtask

    // Small pools: frequent full reports and stack reuse
    task automatic test_small_pool();
        for (int round = 0; round < 3; round++) begin
            wait_idle();
            write_reg(fbpa_pkg::CFG_SLOT_LIMIT,
                      fbpa_pkg::CFG_DATA_W'($urandom_range(2, 16)));
            write_reg(fbpa_pkg::CFG_OBJ_SIZE,
                      fbpa_pkg::CFG_DATA_W'($urandom_range(1, 4096)));
            repeat (50) send_random(55, 85);
        end
    endtask

    // Fill most of the pool at the largest object size, so offsets wrap
    task automatic test_deep_fill();
        wait_idle();
        write_reg(fbpa_pkg::CFG_SLOT_LIMIT, 13'd2047);
        write_reg(fbpa_pkg::CFG_OBJ_SIZE, 13'h1FFF);
        for (int n = 0; n < 1000; n++) begin
            if (n % 100 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            // hold off mid-run until the pipeline is empty
            if (n == 500)
                wait_idle();
            send_random(97, 90);
        end
    endtask

    // Release the pool back-to-back with no stalls on either side
    task automatic test_drain_quiet();
        wait_idle();
        idle_on = 1'b0;
        write_reg(fbpa_pkg::CFG_OBJ_SIZE, 13'd1);
        repeat (150) send_random(25, 90);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reuse_defaults();
        test_limit_edges();
        test_offset_extremes();
        test_small_pool();
        test_deep_fill();
        test_drain_quiet();

        s_axis_tvalid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (miss_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
